@@ src/sctc_pkg.sv @@
// ----------------------------------------------------------------------------
// sctc_pkg
// Shared types, codes and the frame CRC for the SPI command transaction
// checker.
// ----------------------------------------------------------------------------
package sctc_pkg;

	localparam int FRAME_BYTES = 7;
	localparam int FRAME_BITS  = 8 * FRAME_BYTES;
	localparam int CRC_LSB     = 8 * (FRAME_BYTES - 1);
	localparam int ID_LSB      = 8 * (FRAME_BYTES - 2);

	localparam logic [7:0] CRC_POLY = 8'h8C;
	localparam logic [7:0] CRC_PAD  = 8'h3A;
	localparam logic [7:0] CMD_POLL = 8'h00;

	localparam logic [3:0] MAX_RETRIES_RST = 4'd5;
	localparam logic [5:0] MAX_POLLS_RST   = 6'd50;

	localparam int CFG_AW = 2;
	localparam int CFG_DW = 6;

	typedef enum logic [CFG_AW-1:0] {
		REG_MAX_RETRIES = 2'd0,
		REG_MAX_POLLS   = 2'd1
	} reg_idx_t;

	typedef enum logic [2:0] {
		K_REQ  = 3'd0,
		K_POLL = 3'd1,
		K_OK   = 3'd2,
		K_FAIL = 3'd3,
		K_IGN  = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_ECHO = 3'b010,
		PH_POLL = 3'b100
	} phase_t;

	typedef struct packed {
		logic                  action;
		logic [7:0]            command;
		logic [31:0]           payload;
		logic [7:0]            trx_id;
		logic [FRAME_BITS-1:0] rx_frame;
	} item_t;

	typedef struct packed {
		kind_t                 kind;
		logic [FRAME_BITS-1:0] tx_frame;
		logic [31:0]           ret_data;
	} result_t;

	typedef struct packed {
		logic              wr_en;
		logic [CFG_AW-1:0] addr;
		logic [CFG_DW-1:0] wdata;
	} cfg_wr_t;

	typedef logic [FRAME_BITS-1:0][7:0] crc_cols_t;

	// contribution of each frame bit to the reflected CRC-8
	function automatic crc_cols_t crc_cols_f();
		crc_cols_t  cols;
		logic [7:0] c;
		logic       b;
		for (int k = 0; k < FRAME_BITS; k++) begin
			c = '0;
			for (int i = 0; i < FRAME_BITS; i++) begin
				b = c[0] ^ (i == k);
				c = c >> 1;
				if (b) begin
					c = c ^ CRC_POLY;
				end
			end
			cols[k] = c;
		end
		return cols;
	endfunction

	localparam crc_cols_t CRC_COLS = crc_cols_f();

	// CRC over the frame with the pad in the CRC byte
	function automatic logic [7:0] crc8_pad(logic [FRAME_BITS-1:0] frame);
		logic [FRAME_BITS-1:0] v;
		logic [7:0]            c;
		v = {CRC_PAD, frame[CRC_LSB-1:0]};
		c = '0;
		for (int k = 0; k < FRAME_BITS; k++) begin
			if (v[k]) begin
				c = c ^ CRC_COLS[k];
			end
		end
		return c;
	endfunction

endpackage

@@ src/sctc_ctrl.sv @@
// ----------------------------------------------------------------------------
// sctc_ctrl
// Transaction state, configuration registers and the result of one beat.
// ----------------------------------------------------------------------------
module sctc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  sctc_pkg::cfg_wr_t cfg,
	input  logic             step,
	input  sctc_pkg::item_t  item,
	output sctc_pkg::result_t res
);
	import sctc_pkg::*;

	logic [3:0] max_retries_q;
	logic [5:0] max_polls_q;
	phase_t     phase_q;
	logic [7:0] held_command_q;
	logic [31:0] held_payload_q;
	logic [7:0] held_id_q;
	logic [7:0] request_crc_q;
	logic [5:0] poll_count_q;
	logic [3:0] attempt_count_q;

	phase_t     phase_d;
	logic [5:0] poll_count_d;
	logic [3:0] attempt_count_d;
	logic       load;

	logic [FRAME_BITS-1:0] crc_in;
	logic [7:0]            crc_val;
	logic [7:0]            rx_id;
	logic [7:0]            rx_crc;
	logic [4:0]            attempt_next;
	logic [FRAME_BITS-1:0] poll_frame;
	logic [FRAME_BITS-1:0] resend_frame;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_retries_q <= MAX_RETRIES_RST;
			max_polls_q   <= MAX_POLLS_RST;
		end else if (cfg.wr_en) begin
			unique case (cfg.addr)
				REG_MAX_RETRIES: max_retries_q <= cfg.wdata[3:0];
				REG_MAX_POLLS:   max_polls_q   <= cfg.wdata[5:0];
				default: ;
			endcase
		end
	end

	assign crc_in = item.action ? item.rx_frame
	                            : {8'h00, item.trx_id, item.payload, item.command};
	assign crc_val      = crc8_pad(crc_in);
	assign rx_id        = item.rx_frame[ID_LSB +: 8];
	assign rx_crc       = item.rx_frame[CRC_LSB +: 8];
	assign attempt_next = {1'b0, attempt_count_q} + 5'd1;
	assign poll_frame   = {request_crc_q, held_id_q, held_payload_q, CMD_POLL};
	assign resend_frame = {request_crc_q, held_id_q, held_payload_q, held_command_q};

	always_comb begin
		phase_d         = phase_q;
		poll_count_d    = poll_count_q;
		attempt_count_d = attempt_count_q;
		load            = 1'b0;
		res.kind        = K_IGN;
		res.tx_frame    = '0;
		res.ret_data    = '0;
		if (!item.action) begin
			load            = 1'b1;
			phase_d         = PH_ECHO;
			poll_count_d    = '0;
			attempt_count_d = '0;
			res.kind        = K_REQ;
			res.tx_frame    = {crc_val, item.trx_id, item.payload, item.command};
		end else begin
			unique case (phase_q)
				PH_ECHO: begin
					phase_d      = PH_POLL;
					poll_count_d = 6'd1;
					res.kind     = K_POLL;
					res.tx_frame = poll_frame;
				end
				PH_POLL: begin
					if (rx_id == held_id_q && rx_crc == crc_val) begin
						phase_d      = PH_IDLE;
						res.kind     = K_OK;
						res.ret_data = item.rx_frame[39:8];
					end else if (poll_count_q < max_polls_q) begin
						poll_count_d = poll_count_q + 6'd1;
						res.kind     = K_POLL;
						res.tx_frame = poll_frame;
					end else if (attempt_next < {1'b0, max_retries_q}) begin
						attempt_count_d = attempt_next[3:0];
						poll_count_d    = '0;
						phase_d         = PH_ECHO;
						res.kind        = K_REQ;
						res.tx_frame    = resend_frame;
					end else begin
						phase_d  = PH_IDLE;
						res.kind = K_FAIL;
					end
				end
				default: begin
					res.kind = K_IGN;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			poll_count_q    <= '0;
			attempt_count_q <= '0;
		end else if (step) begin
			phase_q         <= phase_d;
			poll_count_q    <= poll_count_d;
			attempt_count_q <= attempt_count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && load) begin
			held_command_q <= item.command;
			held_payload_q <= item.payload;
			held_id_q      <= item.trx_id;
			request_crc_q  <= crc_val;
		end
	end

endmodule

@@ src/spi_command_transaction_checker_core.sv @@
// ----------------------------------------------------------------------------
// spi_command_transaction_checker_core
// Master side of a seven-byte SPI command exchange: builds request and poll
// frames, checks responses and reports success or failure.
// ----------------------------------------------------------------------------
//  channel | signals                                     | beat
//  --------+---------------------------------------------+------------------
//  in      | in_valid in_ready action command payload    | one start or one
//          | trx_id rx_frame                             | received frame
//  out     | out_valid out_ready kind tx_frame ret_data  | one result
//  cfg     | cfg_wr_en cfg_addr cfg_wdata                | one register write
//
// One beat per cycle sustained while the output is not stalled.
// The input register feeds the CRC and sequencing logic, which loads the
// output register. The input side keeps taking beats while the output holds
// a result, as long as that result moves on in the same cycle.
// Reset clears the transaction state and sets max_retries 5, max_polls 50.
// ----------------------------------------------------------------------------
module spi_command_transaction_checker_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [sctc_pkg::CFG_AW-1:0]        cfg_addr,
	input  logic [sctc_pkg::CFG_DW-1:0]        cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               action,
	input  logic [7:0]                         command,
	input  logic [31:0]                        payload,
	input  logic [7:0]                         trx_id,
	input  logic [sctc_pkg::FRAME_BITS-1:0]    rx_frame,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [2:0]                         kind,
	output logic [sctc_pkg::FRAME_BITS-1:0]    tx_frame,
	output logic [31:0]                        ret_data
);
	import sctc_pkg::*;

	item_t   item_s1;
	logic    valid_s1;
	result_t res_q;
	logic    out_valid_q;
	result_t res;
	cfg_wr_t cfg;
	logic    advance;

	assign cfg.wr_en = cfg_wr_en;
	assign cfg.addr  = cfg_addr;
	assign cfg.wdata = cfg_wdata;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.action   <= action;
			item_s1.command  <= command;
			item_s1.payload  <= payload;
			item_s1.trx_id   <= trx_id;
			item_s1.rx_frame <= rx_frame;
		end
	end

	sctc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (advance),
		.item   (item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = res_q.kind;
	assign tx_frame  = res_q.tx_frame;
	assign ret_data  = res_q.ret_data;

endmodule

@@ bench/sctc_txn_monitor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctc_txn_monitor
// Watches the input, output and register ports of the SPI command
// transaction checker, tracks its transaction state, and predicts the
// result of every input beat. Each output beat is compared field by field
// with the oldest predicted result.
// ----------------------------------------------------------------------------
module sctc_txn_monitor (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [sctc_pkg::CFG_AW-1:0]     cfg_addr,
	input  logic [sctc_pkg::CFG_DW-1:0]     cfg_wdata,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic                            action,
	input  logic [7:0]                      command,
	input  logic [31:0]                     payload,
	input  logic [7:0]                      trx_id,
	input  logic [sctc_pkg::FRAME_BITS-1:0] rx_frame,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic [2:0]                      kind,
	input  logic [sctc_pkg::FRAME_BITS-1:0] tx_frame,
	input  logic [31:0]                     ret_data,
	output int                              n_errors,
	output int                              n_pending,
	output int                              n_checked,
	output int                              n_done_ok,
	output int                              n_done_failed
);
	import sctc_pkg::*;

	result_t               awaited_results[$];
	result_t               want;
	result_t               predicted;

	phase_t                txn_phase;
	logic [7:0]            held_cmd;
	logic [31:0]           held_data;
	logic [7:0]            held_tid;
	logic [7:0]            req_crc;
	logic [5:0]            polls_sent;
	logic [3:0]            attempts_failed;
	logic [3:0]            retry_limit;
	logic [5:0]            poll_limit;

	function automatic logic [7:0] frame_crc(logic [FRAME_BITS-1:0] f);
		logic [FRAME_BITS-1:0] v;
		logic [7:0]            c;
		logic                  fb;
		v = f;
		v[CRC_LSB +: 8] = CRC_PAD;
		c = 8'h00;
		for (int i = 0; i < FRAME_BITS; i++) begin
			fb = c[0] ^ v[i];
			c = c >> 1;
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	function automatic logic [FRAME_BITS-1:0] held_frame(logic [7:0] first, logic [7:0] last);
		return {last, held_tid, held_data, first};
	endfunction

	task automatic step_transaction(
		input  logic                  act,
		input  logic [7:0]            cmd,
		input  logic [31:0]           pay,
		input  logic [7:0]            tid,
		input  logic [FRAME_BITS-1:0] rx,
		output result_t               res
	);
		logic [7:0] rid;
		logic [7:0] rcrc;
		res.kind     = K_IGN;
		res.tx_frame = '0;
		res.ret_data = '0;
		rid  = rx[ID_LSB +: 8];
		rcrc = rx[CRC_LSB +: 8];
		if (!act) begin
			held_cmd        = cmd;
			held_data       = pay;
			held_tid        = tid;
			req_crc         = frame_crc(held_frame(cmd, 8'h00));
			polls_sent      = '0;
			attempts_failed = '0;
			txn_phase       = PH_ECHO;
			res.kind        = K_REQ;
			res.tx_frame    = held_frame(held_cmd, req_crc);
		end else if (txn_phase == PH_ECHO) begin
			txn_phase    = PH_POLL;
			polls_sent   = 6'd1;
			res.kind     = K_POLL;
			res.tx_frame = held_frame(CMD_POLL, req_crc);
		end else if (txn_phase == PH_POLL) begin
			if (rid == held_tid && rcrc == frame_crc(rx)) begin
				txn_phase    = PH_IDLE;
				res.kind     = K_OK;
				res.ret_data = rx[8 +: 32];
			end else if (polls_sent < poll_limit) begin
				polls_sent   = polls_sent + 6'd1;
				res.kind     = K_POLL;
				res.tx_frame = held_frame(CMD_POLL, req_crc);
			end else if ({1'b0, attempts_failed} + 5'd1 < {1'b0, retry_limit}) begin
				attempts_failed = attempts_failed + 4'd1;
				polls_sent      = '0;
				txn_phase       = PH_ECHO;
				res.kind        = K_REQ;
				res.tx_frame    = held_frame(held_cmd, req_crc);
			end else begin
				txn_phase = PH_IDLE;
				res.kind  = K_FAIL;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			txn_phase       = PH_IDLE;
			held_cmd        = '0;
			held_data       = '0;
			held_tid        = '0;
			req_crc         = '0;
			polls_sent      = '0;
			attempts_failed = '0;
			retry_limit     = MAX_RETRIES_RST;
			poll_limit      = MAX_POLLS_RST;
			awaited_results.delete();
			n_errors        = 0;
			n_pending       = 0;
			n_checked       = 0;
			n_done_ok       = 0;
			n_done_failed   = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_addr)
					REG_MAX_RETRIES: begin
						retry_limit = cfg_wdata[3:0];
					end
					REG_MAX_POLLS: begin
						poll_limit = cfg_wdata[5:0];
					end
					default: begin
					end
				endcase
			end
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					n_errors++;
					$display("%0t unexpected result: expected none, actual kind %0d frame %h data %h",
						$time, kind, tx_frame, ret_data);
				end else begin
					want = awaited_results.pop_front();
					n_checked++;
					if (want.kind == K_OK) begin
						n_done_ok++;
					end
					if (want.kind == K_FAIL) begin
						n_done_failed++;
					end
					if (kind !== want.kind) begin
						n_errors++;
						$display("%0t kind mismatch: expected %0d actual %0d",
							$time, want.kind, kind);
					end
					if (tx_frame !== want.tx_frame) begin
						n_errors++;
						$display("%0t tx_frame mismatch: expected %h actual %h",
							$time, want.tx_frame, tx_frame);
					end
					if (ret_data !== want.ret_data) begin
						n_errors++;
						$display("%0t ret_data mismatch: expected %h actual %h",
							$time, want.ret_data, ret_data);
					end
				end
			end
			if (in_valid && in_ready) begin
				step_transaction(action, command, payload, trx_id, rx_frame, predicted);
				awaited_results.push_back(predicted);
			end
			n_pending = awaited_results.size();
		end
	end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the SPI command transaction checker: directed
// corner beats, then register settings with random request / poll / reply
// sequences, random gaps on both channels and a long output stall.
// ----------------------------------------------------------------------------
module tb;
	import sctc_pkg::*;

	localparam int CYCLE_LIMIT  = 800000;
	localparam int HOLD_CYCLES  = 300;
	localparam int TARGET_ITEMS = 1700;
	localparam int TAIL_CYCLES  = 20;

	localparam logic [CFG_AW-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_AW-1:0] REG_SPARE_HI = 2'd3;

	localparam logic ACT_START = 1'b0;
	localparam logic ACT_FRAME = 1'b1;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_AW-1:0]     cfg_addr  = '0;
	logic [CFG_DW-1:0]     cfg_wdata = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	logic                  action    = 1'b0;
	logic [7:0]            command   = '0;
	logic [31:0]           payload   = '0;
	logic [7:0]            trx_id    = '0;
	logic [FRAME_BITS-1:0] rx_frame  = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [2:0]            kind;
	logic [FRAME_BITS-1:0] tx_frame;
	logic [31:0]           ret_data;

	int chk_errors;
	int chk_pending;
	int chk_checked;
	int chk_done_ok;
	int chk_done_failed;

	int cycle_cnt      = 0;
	int items_sent     = 0;
	int starts_sent    = 0;
	int settings_used  = 0;
	int eff_retries    = 5;
	int eff_polls      = 50;
	bit send_burst     = 1'b0;
	bit recv_burst     = 1'b0;
	bit hold_long      = 1'b0;

	spi_command_transaction_checker_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.command   (command),
		.payload   (payload),
		.trx_id    (trx_id),
		.rx_frame  (rx_frame),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.tx_frame  (tx_frame),
		.ret_data  (ret_data)
	);

	sctc_txn_monitor u_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.command       (command),
		.payload       (payload),
		.trx_id        (trx_id),
		.rx_frame      (rx_frame),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.tx_frame      (tx_frame),
		.ret_data      (ret_data),
		.n_errors      (chk_errors),
		.n_pending     (chk_pending),
		.n_checked     (chk_checked),
		.n_done_ok     (chk_done_ok),
		.n_done_failed (chk_done_failed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("[spi_command_transaction_checker_core] ERROR");
			$finish;
		end
	end

	// output side: random stall before each beat, one long hold on request
	initial begin
		int n;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_long) begin
				n = HOLD_CYCLES;
				hold_long = 1'b0;
			end else begin
				n = recv_burst ? 0 : $urandom_range(0, 19);
			end
			if (n != 0) begin
				out_ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			@(negedge clk);
		end
	end

	function automatic logic [FRAME_BITS-1:0] rand_frame();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[FRAME_BITS-1:0];
	endfunction

	function automatic logic [FRAME_BITS-1:0] reply_frame(
		logic [7:0] tid, logic [31:0] data, logic [7:0] crc_flip);
		logic [FRAME_BITS-1:0] f;
		logic [7:0]            b0;
		b0 = 8'($urandom);
		f = {8'h00, tid, data, b0};
		f[CRC_LSB +: 8] = crc8_pad(f) ^ crc_flip;
		return f;
	endfunction

	function automatic logic [FRAME_BITS-1:0] bad_reply(logic [7:0] tid);
		logic [7:0] nz;
		nz = 8'($urandom_range(1, 255));
		case ($urandom_range(0, 2))
			0: return reply_frame(tid ^ nz, $urandom, 8'h00);
			1: return reply_frame(tid, $urandom, nz);
			default: return rand_frame();
		endcase
	endfunction

	task automatic send_beat(
		input logic                  act,
		input logic [7:0]            cmd,
		input logic [31:0]           pay,
		input logic [7:0]            tid,
		input logic [FRAME_BITS-1:0] frm
	);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		action   <= act;
		command  <= cmd;
		payload  <= pay;
		trx_id   <= tid;
		rx_frame <= frm;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		items_sent++;
		if (act == ACT_START) begin
			starts_sent++;
		end
	endtask

	task automatic send_frame(input logic [FRAME_BITS-1:0] frm);
		send_beat(ACT_FRAME, 8'($urandom), $urandom, 8'($urandom), frm);
	endtask

	// drop valid and hold until every predicted result has come out
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (chk_pending != 0);
	endtask

	task automatic set_limits(input logic [5:0] r, input logic [5:0] p, input bit stray);
		logic [31:0] junk;
		drain();
		cfg_wr_en <= 1'b1;
		cfg_addr  <= REG_MAX_RETRIES;
		cfg_wdata <= r;
		@(negedge clk);
		cfg_addr  <= REG_MAX_POLLS;
		cfg_wdata <= p;
		@(negedge clk);
		if (stray) begin
			junk = $urandom;
			cfg_addr  <= REG_SPARE_LO;
			cfg_wdata <= junk[CFG_DW-1:0];
			@(negedge clk);
			junk = $urandom;
			cfg_addr  <= REG_SPARE_HI;
			cfg_wdata <= junk[CFG_DW-1:0];
			@(negedge clk);
		end
		cfg_wr_en <= 1'b0;
		eff_retries = (r[3:0] == 4'd0) ? 1 : int'(r[3:0]);
		eff_polls   = (p == 6'd0) ? 1 : int'(p);
		settings_used++;
	endtask

	task automatic failing_txn(input int attempts);
		logic [7:0] tid;
		tid = 8'($urandom);
		send_beat(ACT_START, 8'($urandom), $urandom, tid, rand_frame());
		repeat (attempts) begin
			send_frame(rand_frame());
			send_frame(reply_frame(tid, $urandom, 8'h80));
		end
	endtask

	task automatic run_txn();
		int         budget;
		int         style;
		int         n;
		logic [7:0] tid;
		budget = eff_retries * (eff_polls + 1);
		tid = 8'($urandom);
		send_beat(ACT_START, 8'($urandom), $urandom, tid, rand_frame());
		style = $urandom_range(0, 9);
		if (style == 0) begin
			// abandon midway; the next start takes over
			n = $urandom_range(0, (budget < 8) ? budget - 1 : 7);
			repeat (n) send_frame(bad_reply(tid));
		end else if (style <= 3 && budget <= 130) begin
			repeat (budget) send_frame(bad_reply(tid));
		end else begin
			n = $urandom_range(1, (budget - 1 < 40) ? budget - 1 : 40);
			repeat (n) send_frame(bad_reply(tid));
			send_frame(reply_frame(tid, $urandom, 8'h00));
		end
		if ($urandom_range(0, 4) == 0) begin
			repeat ($urandom_range(1, 2)) send_frame(rand_frame());
		end
	endtask

	task automatic run_phase(
		input logic [5:0] r, input logic [5:0] p, input bit stray, input bit squeeze,
		input int count
	);
		int first;
		bit paused;
		set_limits(r, p, stray);
		send_burst = ($urandom_range(0, 3) == 0);
		recv_burst = ($urandom_range(0, 3) == 0);
		if (squeeze) begin
			send_burst = 1'b1;
			hold_long  = 1'b1;
		end
		first  = items_sent;
		paused = 1'b0;
		while (items_sent - first < count) begin
			run_txn();
			if (squeeze && !paused && items_sent - first >= count / 2) begin
				drain();
				paused = 1'b1;
			end
		end
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset limits: idle frames, extreme fields, bad replies, restart while busy
		send_frame({FRAME_BITS{1'b1}});
		send_frame('0);
		send_beat(ACT_START, 8'hFF, 32'hFFFF_FFFF, 8'hFF, {FRAME_BITS{1'b1}});
		send_frame(rand_frame());
		send_frame(reply_frame(8'hFF, 32'hFFFF_FFFF, 8'h00));
		send_beat(ACT_START, 8'h00, 32'h0000_0000, 8'h00, '0);
		send_frame(rand_frame());
		send_frame(reply_frame(8'h5A, $urandom, 8'h00));
		send_frame(reply_frame(8'h00, $urandom, 8'h01));
		send_beat(ACT_START, 8'hA5, $urandom, 8'h3C, rand_frame());
		send_frame(rand_frame());
		send_frame(reply_frame(8'h3C, 32'h0000_0000, 8'h00));
		send_frame(rand_frame());

		set_limits(6'd1, 6'd1, 1'b0);
		failing_txn(1);
		set_limits(6'd0, 6'd0, 1'b1);
		failing_txn(1);
		set_limits(6'd2, 6'd1, 1'b0);
		failing_txn(2);

		run_phase(6'd15, 6'd63, 1'b0, 1'b0, 100);
		run_phase(6'd1,  6'd1,  1'b0, 1'b1, 150);
		run_phase(6'd0,  6'd0,  1'b1, 1'b0, 80);
		run_phase(6'd15, 6'd1,  1'b0, 1'b0, 120);
		run_phase(6'd1,  6'd63, 1'b0, 1'b0, 150);
		run_phase(6'h37, 6'd2,  1'b0, 1'b0, 100);
		while (items_sent < TARGET_ITEMS) begin
			run_phase(6'($urandom_range(0, 63)),
				6'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
				                               : $urandom_range(0, 6)),
				1'b0, 1'b0, 120);
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d input beats (%0d starts) across %0d register settings",
			items_sent, starts_sent, settings_used);
		$display("compared %0d results: %0d completed, %0d given up after retries",
			chk_checked, chk_done_ok, chk_done_failed);
		if (chk_errors == 0) begin
			$display("[spi_command_transaction_checker_core] OK");
		end else begin
			$display("[spi_command_transaction_checker_core] ERROR");
		end
		$finish;
	end

endmodule

@@ files.f @@
src/sctc_pkg.sv
src/sctc_ctrl.sv
src/spi_command_transaction_checker_core.sv
bench/sctc_txn_monitor.sv
bench/tb.sv
